### rtl/core/lsm_pkg.sv
package lsm_pkg;

    // Widths and limits of the symbol metric datapath.
    localparam int MAX_BITS   = 6;
    localparam int LLR_W      = 16;
    localparam int BPS_W      = 3;
    localparam int SYM_W      = 6;
    localparam int METRIC_W   = 19;
    localparam int TERM_W     = LLR_W + 1;
    localparam int SUM_W      = METRIC_W + 1;
    localparam int SLOT_W     = $clog2(MAX_BITS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BPS_W-1:0] BPS_RESET = BPS_W'(2);

    // One complete symbol position: its bit count and the two metrics of every bit.
    typedef struct packed {
        logic [BPS_W-1:0]                  nbits;
        logic [MAX_BITS-1:0][TERM_W-1:0]   p0;
        logic [MAX_BITS-1:0][TERM_W-1:0]   p1;
    } sym_rec_t;

    // Clamp the programmed bit count into 1 .. MAX_BITS.
    function automatic logic [BPS_W-1:0] eff_bits(input logic [BPS_W-1:0] bps);
        logic [BPS_W-1:0] result;
        result = bps;
        if (bps == '0)
        begin
            result = BPS_W'(1);
        end
        else if (bps > BPS_W'(MAX_BITS))
        begin
            result = BPS_W'(MAX_BITS);
        end
        return result;
    endfunction

endpackage

### rtl/core/lsm_front.sv
module lsm_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [lsm_pkg::BPS_W-1:0]         cfg_write_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [lsm_pkg::LLR_W-1:0]  llr,
    input  logic                              q_full,
    output logic                              q_push,
    output lsm_pkg::sym_rec_t                 q_data
);

    logic [lsm_pkg::BPS_W-1:0]  bps_reg;
    logic [lsm_pkg::BPS_W-1:0]  count_reg;
    logic [lsm_pkg::BPS_W-1:0]  count_next;
    logic [lsm_pkg::TERM_W-1:0] p0_reg [lsm_pkg::MAX_BITS];
    logic [lsm_pkg::TERM_W-1:0] p1_reg [lsm_pkg::MAX_BITS];

    logic [lsm_pkg::BPS_W-1:0]  nbits;
    logic [lsm_pkg::BPS_W-1:0]  slot_full;
    logic [lsm_pkg::SLOT_W-1:0] slot;
    logic                       done;
    logic                       accept;
    logic [lsm_pkg::TERM_W-1:0] llr_ext;
    logic [lsm_pkg::TERM_W-1:0] new_p0;
    logic [lsm_pkg::TERM_W-1:0] new_p1;

    // Slot for the incoming LLR and whether it closes the symbol.
    assign nbits     = lsm_pkg::eff_bits(bps_reg);
    assign slot_full = (count_reg >= nbits) ? '0 : count_reg;
    assign slot      = slot_full[lsm_pkg::SLOT_W-1:0];
    assign done      = (slot_full + lsm_pkg::BPS_W'(1)) == nbits;

    // Only a closing LLR needs room in the queue.
    assign in_stall = q_full && done;
    assign accept   = in_valid && !in_stall;
    assign q_push   = accept && done;

    // Max-log bit metrics: log P1 = -max(llr,0), log P0 = min(llr,0).
    assign llr_ext = {llr[lsm_pkg::LLR_W-1], llr};
    assign new_p1  = (llr > 0) ? (~llr_ext + lsm_pkg::TERM_W'(1)) : '0;
    assign new_p0  = llr[lsm_pkg::LLR_W-1] ? llr_ext : '0;

    // Record for the queue, with the closing LLR merged in.
    always_comb
    begin
        q_data.nbits = nbits;
        for (int i = 0; i < lsm_pkg::MAX_BITS; i++)
        begin
            if (lsm_pkg::SLOT_W'(i) == slot)
            begin
                q_data.p0[i] = new_p0;
                q_data.p1[i] = new_p1;
            end
            else
            begin
                q_data.p0[i] = p0_reg[i];
                q_data.p1[i] = p1_reg[i];
            end
        end
    end

    // Bit counter: a configuration write drops any partial symbol.
    always_comb
    begin
        count_next = count_reg;
        if (cfg_write_en)
        begin
            count_next = '0;
        end
        else if (accept)
        begin
            count_next = done ? '0 : slot_full + lsm_pkg::BPS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg   <= lsm_pkg::BPS_RESET;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_write_en)
            begin
                bps_reg <= cfg_write_data;
            end
        end
    end

    // Held bit metrics of the current symbol.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p0_reg[slot] <= new_p0;
            p1_reg[slot] <= new_p1;
        end
    end

endmodule

### rtl/core/lsm_queue.sv
module lsm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lsm_pkg::sym_rec_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output lsm_pkg::sym_rec_t head
);

    localparam int PTR_W = (lsm_pkg::QUEUE_DEPTH > 1) ? $clog2(lsm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(lsm_pkg::QUEUE_DEPTH + 1);

    lsm_pkg::sym_rec_t entry_reg [lsm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;

    assign full      = count_reg == CNT_W'(lsm_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and fill count update with wraparound.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lsm_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lsm_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/lsm_back.sv
module lsm_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_not_empty,
    input  lsm_pkg::sym_rec_t                    q_head,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lsm_pkg::SYM_W-1:0]            symbol,
    output logic signed [lsm_pkg::METRIC_W-1:0]  metric,
    output logic                                 last
);

    lsm_pkg::sym_rec_t                  cur_reg;
    logic                               active_reg;
    logic                               active_next;
    logic [lsm_pkg::SYM_W-1:0]          k_reg;
    logic [lsm_pkg::SYM_W-1:0]          k_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [lsm_pkg::SYM_W-1:0]          symbol_reg;
    logic [lsm_pkg::METRIC_W-1:0]       metric_reg;
    logic                               last_reg;

    logic [lsm_pkg::SYM_W-1:0]          k_max;
    logic                               is_last;
    logic                               issue;
    logic [lsm_pkg::SUM_W-1:0]          sum;
    logic [lsm_pkg::METRIC_W-1:0]       metric_sat;
    logic [lsm_pkg::BPS_W-1:0]          pos [lsm_pkg::MAX_BITS];
    logic [lsm_pkg::TERM_W-1:0]         term [lsm_pkg::MAX_BITS];

    // Highest symbol index of the current position.
    assign k_max   = lsm_pkg::SYM_W'((lsm_pkg::SYM_W+1)'(1) << cur_reg.nbits)
                   - lsm_pkg::SYM_W'(1);
    assign is_last = k_reg == k_max;

    // One metric leaves per cycle while the output register is free.
    assign issue  = active_reg && (!out_valid_reg || !out_stall);
    assign q_pop  = q_not_empty && (!active_reg || (issue && is_last));

    // Metric of symbol k: first bit maps to the index MSB.
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < lsm_pkg::MAX_BITS; i++)
        begin
            pos[i]  = cur_reg.nbits - lsm_pkg::BPS_W'(1) - lsm_pkg::BPS_W'(i);
            term[i] = '0;
            if (lsm_pkg::BPS_W'(i) < cur_reg.nbits)
            begin
                term[i] = k_reg[pos[i][lsm_pkg::SLOT_W-1:0]] ? cur_reg.p1[i]
                        : cur_reg.p0[i];
            end
            sum = sum + {{(lsm_pkg::SUM_W - lsm_pkg::TERM_W){term[i][lsm_pkg::TERM_W-1]}},
                         term[i]};
        end
    end

    // Clamp to the most negative metric on underflow.
    always_comb
    begin
        if (sum[lsm_pkg::SUM_W-1] != sum[lsm_pkg::METRIC_W-1])
        begin
            metric_sat = {1'b1, {(lsm_pkg::METRIC_W-1){1'b0}}};
        end
        else
        begin
            metric_sat = sum[lsm_pkg::METRIC_W-1:0];
        end
    end

    // Symbol sequencing and output register control.
    always_comb
    begin
        active_next    = active_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (issue)
        begin
            out_valid_next = 1'b1;
            k_next         = k_reg + lsm_pkg::SYM_W'(1);
            if (is_last)
            begin
                active_next = 1'b0;
            end
        end
        if (q_pop)
        begin
            active_next = 1'b1;
            k_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        if (issue)
        begin
            symbol_reg <= k_reg;
            metric_reg <= metric_sat;
            last_reg   <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign metric    = metric_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    // A symbol position is only loaded from a queue that holds one.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_not_empty)
        else $error("lsm_back: pop from empty queue");

    // The index counter never runs past the alphabet of the current position.
    assert property (@(posedge clk) disable iff (!rst_n) active_reg |-> k_reg <= k_max)
        else $error("lsm_back: symbol index beyond alphabet");

    // Within a position, indices leave back to back in increasing order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !last_reg)
        |=> (out_valid_reg && symbol_reg == $past(symbol_reg) + lsm_pkg::SYM_W'(1)))
        else $error("lsm_back: gap or skip in symbol sequence");
`endif

endmodule

### rtl/core/llr_to_symbol_maxlog_metric_core.sv
// Max-log symbol metrics from a stream of bit LLRs.
// Each symbol passes the queue, the current-position register and the output register
// after its last LLR transfer. One LLR per cycle in while in_stall is low; one metric
// per cycle out while out_stall allows, 2^bits_per_symbol per symbol, pacing the input.
// Reset clears the bit counter, the queue and the output; bits_per_symbol resets to 2.
module llr_to_symbol_maxlog_metric_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [lsm_pkg::BPS_W-1:0]            cfg_write_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [lsm_pkg::LLR_W-1:0]     llr,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lsm_pkg::SYM_W-1:0]            symbol,
    output logic signed [lsm_pkg::METRIC_W-1:0]  metric,
    output logic                                 last
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_not_empty;
    lsm_pkg::sym_rec_t q_push_data;
    lsm_pkg::sym_rec_t q_head;

    // Collects LLRs into complete symbol positions.
    lsm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .llr            (llr),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_push_data)
    );

    // Short queue between collection and expansion.
    lsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Expands each position into one metric per symbol index.
    lsm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .symbol      (symbol),
        .metric      (metric),
        .last        (last)
    );

endmodule
